// ----- hdl/sdb_pkg.sv -----
`timescale 1ns / 1ps

package sdb_pkg;

  localparam int DIGITS = 4;

  // operation codes of an input word
  localparam logic [2:0] OP_TICK        = 3'd0;
  localparam logic [2:0] OP_SET_BASE    = 3'd1;
  localparam logic [2:0] OP_BLINK       = 3'd2;
  localparam logic [2:0] OP_STOP        = 3'd3;
  localparam logic [2:0] OP_SCROLL_BYTE = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_BLINK  = 2'd0;
  localparam logic [1:0] CFG_FLASH  = 2'd1;
  localparam logic [1:0] CFG_SCROLL = 2'd2;
  localparam logic [1:0] CFG_PAUSE  = 2'd3;

  localparam logic [15:0] BLINK_RESET  = 16'd250;
  localparam logic [15:0] FLASH_RESET  = 16'd100;
  localparam logic [15:0] SCROLL_RESET = 16'd300;
  localparam logic [15:0] PAUSE_RESET  = 16'd1000;

  localparam logic [2:0] NO_DIGIT = 3'd4;
  localparam logic [1:0] FLASHES  = 2'd3;
  localparam int         PAD      = 4;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_BLINK,
    MODE_FLASH,
    MODE_SCROLL,
    MODE_PAUSE
  } mode_t;

  typedef logic [DIGITS-1:0][7:0] digits_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] base_digit_0;
    logic [7:0] base_digit_1;
    logic [7:0] base_digit_2;
    logic [7:0] base_digit_3;
    logic [2:0] blink_index;
    logic [7:0] scroll_segment;
    logic       scroll_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] show_digit_0;
    logic [7:0] show_digit_1;
    logic [7:0] show_digit_2;
    logic [7:0] show_digit_3;
  } out_item_t;

  // pending result: fixed bytes, or a window taken from the text banks
  typedef struct packed {
    logic              win;
    logic [DIGITS-1:0] win_mask;
    logic [1:0]        pos_lo;
    digits_t           bytes;
  } res_t;

endpackage

// ----- hdl/segment_display_blink_scroll_sequencer_unit.sv -----
`timescale 1ns / 1ps
// A result word passes the input register, then the mode update with text
// bank read, then the output register.
// Throughput: one input word per cycle; stalls only pass back from out_stall.
// Reset clears mode state, counters, base digits and the intervals to their
// defaults at once; the scroll text banks are not cleared and need no sweep.
module segment_display_blink_scroll_sequencer_unit #(
  parameter int SCROLL_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sdb_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output sdb_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import sdb_pkg::*;

  localparam int ROWS = (SCROLL_DEPTH + 3) / 4;
  localparam int RW = $clog2(ROWS);

  logic     v0_r;
  in_item_t item_r;
  logic     res_free;
  logic     go;
  logic     accept;

  logic             emit;
  res_t             res;
  logic             wr_en;
  logic [1:0]       wr_bank;
  logic [RW-1:0]    wr_row;
  logic             rd_en;
  logic [3:0][RW-1:0] rd_row;
  digits_t          bank_q;

  assign go       = v0_r && res_free;
  assign in_stall = v0_r && !res_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (accept) begin
      v0_r <= 1'b1;
    end else if (go) begin
      v0_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  sdb_ctrl #(.SCROLL_DEPTH(SCROLL_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .item      (item_r),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .emit      (emit),
    .res       (res),
    .wr_en     (wr_en),
    .wr_bank   (wr_bank),
    .wr_row    (wr_row),
    .rd_en     (rd_en),
    .rd_row    (rd_row)
  );

  sdb_text_store #(.SCROLL_DEPTH(SCROLL_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_bank (wr_bank),
    .wr_row  (wr_row),
    .wr_data (item_r.scroll_segment),
    .rd_en   (rd_en),
    .rd_row  (rd_row),
    .rd_data (bank_q)
  );

  sdb_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (go),
    .emit      (emit),
    .res       (res),
    .bank_q    (bank_q),
    .out_stall (out_stall),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- hdl/sdb_text_store.sv -----
`timescale 1ns / 1ps

module sdb_text_store #(
  parameter int SCROLL_DEPTH = 64,
  localparam int ROWS = (SCROLL_DEPTH + 3) / 4,
  localparam int RW = $clog2(ROWS)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [1:0]            wr_bank,
  input  logic [RW-1:0]         wr_row,
  input  logic [7:0]            wr_data,
  input  logic                  rd_en,
  input  logic [3:0][RW-1:0]    rd_row,
  output sdb_pkg::digits_t      rd_data
);
  import sdb_pkg::*;

  // four interleaved banks: text index t lives in bank t%4, row t/4
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0] mem [ROWS];
    logic [7:0] q_r;

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == 2'(b))) begin
        mem[wr_row] <= wr_data;
      end
      if (rd_en) begin
        q_r <= mem[rd_row[b]];
      end
    end
  end

  assign rd_data = {g_bank[3].q_r, g_bank[2].q_r, g_bank[1].q_r, g_bank[0].q_r};

endmodule

// ----- hdl/sdb_ctrl.sv -----
`timescale 1ns / 1ps

module sdb_ctrl #(
  parameter int SCROLL_DEPTH = 64,
  localparam int ROWS = (SCROLL_DEPTH + 3) / 4,
  localparam int RW = $clog2(ROWS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  sdb_pkg::in_item_t     item,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_wdata,
  output logic                  emit,
  output sdb_pkg::res_t         res,
  output logic                  wr_en,
  output logic [1:0]            wr_bank,
  output logic [RW-1:0]         wr_row,
  output logic                  rd_en,
  output logic [3:0][RW-1:0]    rd_row
);
  import sdb_pkg::*;

  localparam int LW = $clog2(SCROLL_DEPTH + 1);
  localparam int PW = $clog2(SCROLL_DEPTH + 6);

  logic [15:0] blink_iv_r, flash_iv_r, scroll_iv_r, pause_iv_r;

  mode_t       mode_r, mode_nxt;
  logic [15:0] el_r, el_nxt;
  logic        phase_r, phase_nxt;
  logic [1:0]  fc_r, fc_nxt;
  logic [2:0]  bd_r, bd_nxt;
  digits_t     base_r, base_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [LW-1:0] lptr_r, lptr_nxt;

  logic [15:0]   el_inc;
  logic [15:0]   iv;
  logic          fire;
  logic          stop_req;
  logic          room;
  logic [LW-1:0] lptr_adv;
  logic [1:0]    fc_inc;
  logic [PW:0]   len_end;
  logic [PW:0]   pos_inc_ext;
  logic [DIGITS-1:0] win_mask;
  digits_t       new_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_iv_r  <= BLINK_RESET;
      flash_iv_r  <= FLASH_RESET;
      scroll_iv_r <= SCROLL_RESET;
      pause_iv_r  <= PAUSE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLINK:  blink_iv_r  <= cfg_wdata;
        CFG_FLASH:  flash_iv_r  <= cfg_wdata;
        CFG_SCROLL: scroll_iv_r <= cfg_wdata;
        CFG_PAUSE:  pause_iv_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    el_inc = (el_r != 16'hFFFF) ? el_r + 16'd1 : el_r;
    unique case (mode_r)
      MODE_BLINK:  iv = blink_iv_r;
      MODE_FLASH:  iv = flash_iv_r;
      MODE_SCROLL: iv = scroll_iv_r;
      MODE_PAUSE:  iv = pause_iv_r;
      default:     iv = 16'hFFFF;
    endcase
    fire = (el_inc >= iv);

    room     = (lptr_r < LW'(SCROLL_DEPTH));
    lptr_adv = room ? lptr_r + LW'(1) : lptr_r;
    fc_inc   = (fc_r != FLASHES) ? fc_r + 2'd1 : fc_r;
    len_end  = (PW+1)'(len_r) + (PW+1)'(PAD);
    pos_inc_ext = (PW+1)'(pos_r) + (PW+1)'(1);

    new_base = {item.base_digit_3, item.base_digit_2, item.base_digit_1, item.base_digit_0};
  end

  // window of four padded positions starting at the scroll position
  always_comb begin
    logic [PW:0] p;
    logic [PW:0] s;
    logic [1:0]  ib;
    for (int i = 0; i < DIGITS; i++) begin
      p = (PW+1)'(pos_r) + (PW+1)'(i);
      win_mask[i] = (p >= (PW+1)'(PAD)) && (p < len_end);
    end
    for (int b = 0; b < 4; b++) begin
      ib = 2'(b) - pos_r[1:0];
      s  = (PW+1)'(pos_r) + (PW+1)'(ib);
      rd_row[b] = RW'((s >> 2) - (PW+1)'(1));
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    el_nxt    = el_r;
    phase_nxt = phase_r;
    fc_nxt    = fc_r;
    bd_nxt    = bd_r;
    base_nxt  = base_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    lptr_nxt  = lptr_r;
    emit      = 1'b0;
    res       = '0;
    rd_en     = 1'b0;
    stop_req  = 1'b0;
    wr_en     = go && (item.operation == OP_SCROLL_BYTE) && room;
    wr_bank   = lptr_r[1:0];
    wr_row    = RW'(lptr_r >> 2);

    if (go) begin
      unique case (item.operation)
        OP_TICK: begin
          el_nxt = el_inc;
          unique case (mode_r)
            MODE_BLINK: begin
              if (fire) begin
                el_nxt    = '0;
                phase_nxt = ~phase_r;
                emit      = 1'b1;
                res.bytes = base_r;
                // blank the chosen digit on the off phase
                if (phase_r && (bd_r < NO_DIGIT)) begin
                  res.bytes[bd_r[1:0]] = 8'd0;
                end
              end
            end
            MODE_FLASH: begin
              if (fire) begin
                el_nxt    = '0;
                phase_nxt = ~phase_r;
                emit      = 1'b1;
                if (!phase_r) begin
                  res.bytes = base_r;
                end else begin
                  fc_nxt = fc_inc;
                  if (fc_inc == FLASHES) begin
                    mode_nxt = MODE_SCROLL;
                  end
                end
              end
            end
            MODE_SCROLL: begin
              if (fire) begin
                el_nxt       = '0;
                emit         = 1'b1;
                rd_en        = 1'b1;
                res.win      = 1'b1;
                res.win_mask = win_mask;
                res.pos_lo   = pos_r[1:0];
                pos_nxt      = pos_r + PW'(1);
                if (pos_inc_ext > len_end) begin
                  mode_nxt = MODE_PAUSE;
                end
              end
            end
            MODE_PAUSE: begin
              if (fire) begin
                mode_nxt  = MODE_IDLE;
                bd_nxt    = NO_DIGIT;
                emit      = 1'b1;
                res.bytes = base_r;
              end
            end
            default: ;
          endcase
        end
        OP_SET_BASE: begin
          base_nxt = new_base;
          if ((mode_r == MODE_IDLE) || (mode_r == MODE_BLINK)) begin
            emit      = 1'b1;
            res.bytes = new_base;
          end
        end
        OP_BLINK: begin
          if ((mode_r != MODE_SCROLL) && (mode_r != MODE_FLASH)) begin
            if (item.blink_index < NO_DIGIT) begin
              bd_nxt    = item.blink_index;
              mode_nxt  = MODE_BLINK;
              phase_nxt = 1'b1;
              el_nxt    = '0;
              emit      = 1'b1;
              res.bytes = base_r;
            end else begin
              stop_req = 1'b1;
            end
          end
        end
        OP_STOP: stop_req = 1'b1;
        OP_SCROLL_BYTE: begin
          lptr_nxt = lptr_adv;
          if (item.scroll_last) begin
            len_nxt   = lptr_adv;
            lptr_nxt  = '0;
            mode_nxt  = MODE_FLASH;
            fc_nxt    = '0;
            phase_nxt = 1'b0;
            pos_nxt   = '0;
            el_nxt    = '0;
            emit      = 1'b1;
          end
        end
        default: ;
      endcase

      if (stop_req && (mode_r == MODE_BLINK)) begin
        bd_nxt    = NO_DIGIT;
        mode_nxt  = MODE_IDLE;
        emit      = 1'b1;
        res.bytes = base_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      el_r    <= '0;
      phase_r <= 1'b0;
      fc_r    <= '0;
      bd_r    <= NO_DIGIT;
      base_r  <= '0;
      len_r   <= '0;
      pos_r   <= '0;
      lptr_r  <= '0;
    end else begin
      mode_r  <= mode_nxt;
      el_r    <= el_nxt;
      phase_r <= phase_nxt;
      fc_r    <= fc_nxt;
      bd_r    <= bd_nxt;
      base_r  <= base_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      lptr_r  <= lptr_nxt;
    end
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_SCROLL) |-> ((PW+1)'(pos_r) <= len_end))
    else $error("scroll position ran past the padded text");

  a_lptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (lptr_r <= LW'(SCROLL_DEPTH)) && (len_r <= LW'(SCROLL_DEPTH)))
    else $error("load pointer or text length beyond the store");

  a_blink_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_BLINK) |-> (bd_r < NO_DIGIT))
    else $error("blink mode without a digit");

  a_read_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (go && (mode_r == MODE_SCROLL) && emit))
    else $error("text read outside a scroll step");

  a_scroll_entry: assert property (@(posedge clk) disable iff (!rst_n)
    ((mode_r == MODE_FLASH) && (mode_nxt == MODE_SCROLL)) |=> (fc_r == FLASHES))
    else $error("scroll started before the last flash");

endmodule

// ----- hdl/sdb_out_stage.sv -----
`timescale 1ns / 1ps

module sdb_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                emit,
  input  sdb_pkg::res_t       res,
  input  sdb_pkg::digits_t    bank_q,
  input  logic                out_stall,
  output logic                res_free,
  output logic                out_valid,
  output sdb_pkg::out_item_t  out_item
);
  import sdb_pkg::*;

  logic      v1_r;
  res_t      res_r;
  logic      v2_r;
  out_item_t out_r;
  logic      adv;
  digits_t   shown;

  assign adv      = v1_r && (!v2_r || !out_stall);
  assign res_free = !v1_r || adv;

  // window result: pick each digit from its bank, blank outside the text; else fixed bytes
  always_comb begin
    logic [1:0] bank;
    for (int i = 0; i < DIGITS; i++) begin
      bank = res_r.pos_lo + 2'(i);
      if (res_r.win) begin
        shown[i] = res_r.win_mask[i] ? bank_q[bank] : 8'd0;
      end else begin
        shown[i] = res_r.bytes[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (load) begin
        v1_r <= emit;
      end else if (adv) begin
        v1_r <= 1'b0;
      end
      if (adv) begin
        v2_r <= 1'b1;
      end else if (!out_stall) begin
        v2_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
    if (adv) begin
      out_r.show_digit_0 <= shown[0];
      out_r.show_digit_1 <= shown[1];
      out_r.show_digit_2 <= shown[2];
      out_r.show_digit_3 <= shown[3];
    end
  end

  assign out_valid = v2_r;
  assign out_item  = out_r;

endmodule
